// File: src/cdt_pkg.sv
// Shared constants, command and phase codes, and controller/datapath link types
// for the countdown timer with progress. No dependencies.
`default_nettype none

package cdt_pkg;

  // Defaults for the top-level parameters
  localparam int SECONDS_BITS_DEF = 20;
  localparam int FULL_SCALE_DEF   = 10000;

  // Fixed widths
  localparam int TICK_BITS = 32;
  localparam int PROG_BITS = 14;
  localparam int TPS_BITS  = 8;
  localparam int CMD_BITS  = 3;
  localparam int PH_BITS   = 2;

  localparam logic [TPS_BITS-1:0] TPS_RESET = 8'd10;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_START  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_PAUSE  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_RESUME = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_RESET  = 3'd4;

  // Phase codes
  localparam logic [PH_BITS-1:0] PH_RESET = 2'd0;
  localparam logic [PH_BITS-1:0] PH_RUN   = 2'd1;
  localparam logic [PH_BITS-1:0] PH_PAUSE = 2'd2;
  localparam logic [PH_BITS-1:0] PH_OVER  = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // capture the input word
    logic apply;       // execute a non-tick command (or an ignored tick)
    logic tick_start;  // bump tick count, load remainder unit, form total ticks
    logic tick_left;   // form ticks left
    logic tick_mul;    // scale ticks left and load the progress divider
    logic iter_mod;    // one remainder step
    logic iter_div;    // one progress divider step
    logic commit;      // update seconds, overtime, progress, finished
    logic load_out;    // load the output register
  } cdt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tick_live;   // latched word is a tick that counts
    logic out_busy;    // output register holds a word not yet taken
  } cdt_status_t;

endpackage

`default_nettype wire

// File: src/cdt_ctrl.sv
// Sequencer for the countdown timer: accepts a word, steps the datapath
// through the tick arithmetic and publishes the result. Uses cdt_pkg.
`default_nettype none

module cdt_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  cdt_pkg::cdt_status_t st,
  output cdt_pkg::cdt_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_LEFT   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_ITER   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_PUB    = 3'd6;

  localparam int STEP_BITS = $clog2(cdt_pkg::TICK_BITS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(cdt_pkg::TICK_BITS - 1);
  localparam logic [STEP_BITS-1:0] DIV_STEPS = STEP_BITS'(cdt_pkg::PROG_BITS);

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [STEP_BITS-1:0] step;

  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    state_next    = state;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.tick_live) begin
          cmd.tick_start = 1'b1;
          state_next     = S_LEFT;
        end else begin
          cmd.apply  = 1'b1;
          state_next = S_PUB;
        end
      end
      S_LEFT: begin
        cmd.tick_left = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.tick_mul = 1'b1;
        state_next   = S_ITER;
      end
      S_ITER: begin
        cmd.iter_mod = 1'b1;
        cmd.iter_div = (step < DIV_STEPS);
        if (step == STEP_LAST) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_PUB;
      end
      S_PUB: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_ITER) step <= step + 1'b1;
      else                 step <= '0;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !st.out_busy)
    else $error("output register loaded while still occupied");

  a_div_inside_iter: assert property (@(posedge clk) disable iff (rst)
    cmd.iter_div |-> cmd.iter_mod)
    else $error("divider step outside the iteration window");

  a_iter_from_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER && $past(state) != S_ITER) |-> step == '0)
    else $error("iteration did not start at step zero");

endmodule

`default_nettype wire

// File: src/cdt_datapath.sv
// Timer state, remainder unit, progress divider and output register for the
// countdown timer. Driven by cdt_ctrl commands; uses cdt_pkg.
`default_nettype none

module cdt_datapath #(
  parameter int SECONDS_BITS = cdt_pkg::SECONDS_BITS_DEF,
  parameter int FULL_SCALE   = cdt_pkg::FULL_SCALE_DEF,
  parameter int IN_W         = ((SECONDS_BITS + 7) / 8) * 8,
  parameter int OUT_W        = ((2 * SECONDS_BITS + cdt_pkg::PROG_BITS
                                 + cdt_pkg::PH_BITS + 1 + 7) / 8) * 8
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [cdt_pkg::TPS_BITS-1:0]     cfg_wdata,
  input  wire  [IN_W-1:0]                  s_axis_tdata,
  input  wire  [cdt_pkg::CMD_BITS-1:0]     s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [OUT_W-1:0]                 m_axis_tdata,
  input  cdt_pkg::cdt_cmd_t                cmd,
  output cdt_pkg::cdt_status_t             st
);

  localparam int SB   = SECONDS_BITS;
  localparam int TB   = cdt_pkg::TICK_BITS;
  localparam int PB   = cdt_pkg::PROG_BITS;
  localparam int WB   = cdt_pkg::TPS_BITS;
  localparam int AW   = SB + WB;                 // total ticks
  localparam int CW   = (AW > TB) ? AW : TB;     // compare width
  localparam int DW   = AW + PB;                 // scaled ticks left
  localparam int USED = 2 * SB + PB + cdt_pkg::PH_BITS + 1;
  localparam int PADW = OUT_W - USED;

  // Configuration and latched word
  logic [WB-1:0]                  tps;
  logic [cdt_pkg::CMD_BITS-1:0]   item_cmd;
  logic [SB-1:0]                  item_secs;

  // Timer state
  logic [cdt_pkg::PH_BITS-1:0]    phase;
  logic                           exists;
  logic [TB-1:0]                  tick_count;
  logic [SB-1:0]                  remaining;
  logic [SB-1:0]                  total;
  logic [SB-1:0]                  overtime;
  logic [PB-1:0]                  progress;
  logic                           fin;

  // Arithmetic work registers
  logic [AW-1:0]                  all_ticks;
  logic [AW-1:0]                  left;
  logic [WB-1:0]                  mod_rem;
  logic [TB-1:0]                  mod_sh;
  logic [AW-1:0]                  div_rem;
  logic [PB-1:0]                  div_low;
  logic [PB-1:0]                  div_q;

  logic [WB-1:0]                  tps_eff;
  logic [TB-1:0]                  tick_inc;
  logic [CW-1:0]                  all_x;
  logic [CW-1:0]                  tc_x;
  logic [CW-1:0]                  diff_x;
  logic [DW-1:0]                  scaled;
  logic [WB:0]                    mod_try;
  logic [AW:0]                    div_try;
  logic                           sec_edge;
  logic [SB-1:0]                  remaining_next;
  logic [PB-1:0]                  prog_clamped;

  assign tps_eff  = (tps == '0) ? WB'(1) : tps;
  assign tick_inc = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign all_x    = CW'(all_ticks);
  assign tc_x     = CW'(tick_count);
  assign diff_x   = all_x - tc_x;
  assign scaled   = DW'(left) * DW'(FULL_SCALE);
  assign mod_try  = {mod_rem, mod_sh[TB-1]};
  assign div_try  = {div_rem, div_low[PB-1]};

  assign sec_edge       = (mod_rem == '0);
  assign remaining_next = (sec_edge && remaining != '0) ? remaining - 1'b1 : remaining;
  assign prog_clamped   = (div_q > PB'(FULL_SCALE)) ? PB'(FULL_SCALE) : div_q;

  assign st.tick_live = (item_cmd == cdt_pkg::CMD_TICK) &&
                        (phase == cdt_pkg::PH_RUN || phase == cdt_pkg::PH_OVER);
  assign st.out_busy  = m_axis_tvalid && !m_axis_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst)         tps <= cdt_pkg::TPS_RESET;
    else if (cfg_we) tps <= cfg_wdata;
  end

  // Latched word and arithmetic work registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_cmd  <= s_axis_tuser;
      item_secs <= s_axis_tdata[SB-1:0];
    end
    if (cmd.tick_start) begin
      all_ticks <= AW'(total) * AW'(tps_eff);
      mod_rem   <= '0;
      mod_sh    <= tick_inc;
    end
    if (cmd.tick_left) begin
      left <= (all_x > tc_x) ? AW'(diff_x) : '0;
    end
    if (cmd.tick_mul) begin
      div_rem <= scaled[DW-1:PB];
      div_low <= scaled[PB-1:0];
      div_q   <= '0;
    end
    if (cmd.iter_mod) begin
      // shift in one dividend bit, subtract the tick rate when it fits
      mod_sh <= {mod_sh[TB-2:0], 1'b0};
      if (mod_try >= {1'b0, tps_eff}) mod_rem <= WB'(mod_try - {1'b0, tps_eff});
      else                            mod_rem <= mod_try[WB-1:0];
    end
    if (cmd.iter_div) begin
      div_low <= {div_low[PB-2:0], 1'b0};
      if (div_try >= {1'b0, all_ticks}) begin
        div_rem <= AW'(div_try - {1'b0, all_ticks});
        div_q   <= {div_q[PB-2:0], 1'b1};
      end else begin
        div_rem <= div_try[AW-1:0];
        div_q   <= {div_q[PB-2:0], 1'b0};
      end
    end
  end

  // Timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= cdt_pkg::PH_RESET;
      exists     <= 1'b0;
      tick_count <= '0;
      remaining  <= '0;
      total      <= '0;
      overtime   <= '0;
      progress   <= '0;
      fin        <= 1'b0;
    end else begin
      if (cmd.apply) begin
        fin <= 1'b0;
        unique case (item_cmd)
          cdt_pkg::CMD_START: begin
            if (!exists && item_secs != '0) begin
              tick_count <= '0;
              progress   <= PB'(FULL_SCALE);
              remaining  <= item_secs;
              total      <= item_secs;
              overtime   <= '0;
              phase      <= cdt_pkg::PH_RUN;
              exists     <= 1'b1;
            end
          end
          cdt_pkg::CMD_PAUSE:  if (exists) phase <= cdt_pkg::PH_PAUSE;
          cdt_pkg::CMD_RESUME: if (exists) phase <= cdt_pkg::PH_RUN;
          cdt_pkg::CMD_RESET: begin
            phase      <= cdt_pkg::PH_RESET;
            exists     <= 1'b0;
            tick_count <= '0;
            remaining  <= '0;
            total      <= '0;
            overtime   <= '0;
            progress   <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.tick_start) begin
        tick_count <= tick_inc;
        fin        <= 1'b0;
      end
      if (cmd.commit) begin
        remaining <= remaining_next;
        if (sec_edge) begin
          if (remaining != '0) begin
            if (remaining_next == '0) begin
              phase <= cdt_pkg::PH_OVER;
              fin   <= 1'b1;
            end
          end else if (overtime != '1) begin
            overtime <= overtime + 1'b1;
          end
        end
        if (remaining_next != '0 && all_ticks != '0) progress <= prog_clamped;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)                m_axis_tvalid <= 1'b0;
    else if (cmd.load_out)  m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out)
      m_axis_tdata <= {PADW'(0), fin, progress, overtime, remaining, phase};
  end

  a_remaining_needs_run: assert property (@(posedge clk) disable iff (rst)
    (remaining != '0) |-> exists)
    else $error("seconds left without a countdown");

  a_remaining_le_total: assert property (@(posedge clk) disable iff (rst)
    remaining <= total)
    else $error("remaining seconds exceed the loaded total");

  a_fin_means_over: assert property (@(posedge clk) disable iff (rst)
    $rose(fin) |-> (phase == cdt_pkg::PH_OVER && remaining == '0))
    else $error("finished raised outside the over phase");

endmodule

`default_nettype wire

// File: src/countdown_timer_with_progress_unit.sv
// Top level of the countdown timer with progress: joins the sequencer and the
// datapath. Depends on cdt_pkg, cdt_ctrl and cdt_datapath.
`default_nettype none

// A seconds countdown driven by command words. Each input word carries a
// command in s_axis_tuser (tick, start, pause, resume, reset) and, for start,
// a second count in s_axis_tdata; every accepted word yields exactly one
// output word with the phase, remaining and overtime seconds, the progress
// value (FULL_SCALE means full) and a finished flag that is set only on the
// tick where the countdown reaches zero. The block works on one word at a
// time. A tick that counts (phase running or over) goes from acceptance
// through EXEC, LEFT, MUL, ITER, COMMIT and PUB to the output register, and
// the next word can be taken in the cycle after it is staged: in ITER the
// 32-bit tick count is reduced modulo ticks_per_second one bit per cycle,
// and the 14-bit progress quotient is formed alongside by a shift-subtract
// divider after a multiply by FULL_SCALE. Every other command goes from
// acceptance through EXEC and PUB to the output register. The output
// register decouples the two sides; a new word is taken as soon as the
// previous one is staged, even if the consumer has not yet taken it, and
// the block only waits when the word before that one is still sitting in
// the output register. ticks_per_second is written with cfg_we/cfg_wdata
// by the user while idle, which the block does not enforce; zero acts as one.
module countdown_timer_with_progress_unit #(
  parameter int SECONDS_BITS = cdt_pkg::SECONDS_BITS_DEF,
  parameter int FULL_SCALE   = cdt_pkg::FULL_SCALE_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst,
  // configuration: ticks_per_second
  input  wire                                     cfg_we,
  input  wire  [cdt_pkg::TPS_BITS-1:0]            cfg_wdata,
  // input words
  input  wire                                     s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [SECONDS_BITS-1:0] start_seconds, rest zero
  input  wire  [((SECONDS_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // [2:0] cmd
  input  wire  [cdt_pkg::CMD_BITS-1:0]            s_axis_tuser,
  // output words
  output logic                                    m_axis_tvalid,
  input  wire                                     m_axis_tready,
  // from bit 0 up: phase (2), remaining_seconds (SECONDS_BITS),
  // overtime_seconds (SECONDS_BITS), progress (14), finished (1), zero pad
  output logic [((2 * SECONDS_BITS + cdt_pkg::PROG_BITS + cdt_pkg::PH_BITS + 1 + 7) / 8)
                * 8 - 1:0]                        m_axis_tdata
);

  localparam int IN_W  = ((SECONDS_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2 * SECONDS_BITS + cdt_pkg::PROG_BITS
                           + cdt_pkg::PH_BITS + 1 + 7) / 8) * 8;

  cdt_pkg::cdt_cmd_t    cmd;
  cdt_pkg::cdt_status_t st;

  // Sequence each word through the datapath
  cdt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .st            (st),
    .cmd           (cmd)
  );

  // Hold timer state, run the remainder and progress arithmetic, stage output
  cdt_datapath #(
    .SECONDS_BITS (SECONDS_BITS),
    .FULL_SCALE   (FULL_SCALE),
    .IN_W         (IN_W),
    .OUT_W        (OUT_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

`default_nettype wire
